### hdl/lcsl_pkg.sv
// Shared types, codes and helpers for the LSDA call-site lookup.
// No dependencies; every other file imports this package.
package lcsl_pkg;

    localparam int OFFSET_BITS_DEF = 33;

    localparam logic [7:0] ENC_OMIT  = 8'hFF;
    localparam logic [3:0] FMT_ABS8  = 4'h0;
    localparam logic [3:0] FMT_ULEB  = 4'h1;
    localparam logic [3:0] FMT_U2    = 4'h2;
    localparam logic [3:0] FMT_U4    = 4'h3;
    localparam logic [3:0] FMT_U8    = 4'h4;
    localparam logic [3:0] FMT_SLEB  = 4'h9;
    localparam logic [3:0] FMT_S2    = 4'hA;
    localparam logic [3:0] FMT_S4    = 4'hB;
    localparam logic [3:0] FMT_S8    = 4'hC;
    localparam logic [2:0] REL_ABS   = 3'd0;
    localparam logic [2:0] REL_PC    = 3'd1;

    localparam logic [1:0] CFG_CALL_IP      = 2'd0;
    localparam logic [1:0] CFG_REGION_START = 2'd1;
    localparam logic [1:0] CFG_LSDA_ADDRESS = 2'd2;

    localparam logic [1:0] EF_START = 2'd0;
    localparam logic [1:0] EF_PAD   = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FORMAT   = 3'd1,
        ST_REL      = 3'd2,
        ST_INDIRECT = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_LP_ENC    = 9'b000000010,
        PH_LP_FIELD  = 9'b000000100,
        PH_TT_ENC    = 9'b000001000,
        PH_TT_SKIP   = 9'b000010000,
        PH_CS_ENC    = 9'b000100000,
        PH_CS_LEN    = 9'b001000000,
        PH_CS_FIELD  = 9'b010000000,
        PH_CS_ACTION = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [63:0] pad;
        status_t     status;
    } result_t;

    function automatic logic [3:0] fixed_len(input logic [3:0] fmt);
        logic [3:0] n;
        case (fmt)
            FMT_ABS8, FMT_U8, FMT_S8: n = 4'd8;
            FMT_U2, FMT_S2:           n = 4'd2;
            FMT_U4, FMT_S4:           n = 4'd4;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic status_t check_enc(input logic [7:0] enc);
        status_t s;
        s = ST_OK;
        if (!(enc[3:0] == FMT_ULEB || enc[3:0] == FMT_SLEB || fixed_len(enc[3:0]) != 4'd0))
            s = ST_FORMAT;
        else if (enc[6:4] != REL_ABS && enc[6:4] != REL_PC)
            s = ST_REL;
        return s;
    endfunction

endpackage

### hdl/lsda_call_site_lookup.sv
// Top level of the LSDA call-site lookup: config registers, input register,
// parser and result register. Uses lcsl_pkg and lcsl_parse.
//
// The block takes one LSDA byte per transfer and closes each search with
// exactly one result: found, handler_addr and status. A byte with first_byte
// set starts a search at offset zero; bytes outside a search are dropped
// silently. The block sustains one byte per cycle while the output is not
// stalled: every byte is parsed combinationally between the input register
// and the result register. Input stalls only while a result waits in the
// output register and the sink holds out_stall.
// Write call_ip, region_start and lsda_address between searches.
module lsda_call_site_lookup
    import lcsl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [63:0] handler_addr,
    output logic [2:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] call_ip_reg, region_start_reg, lsda_address_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_first_reg, s1_last_reg;
    logic        out_valid_reg, found_reg;
    logic [63:0] pad_reg;
    status_t     status_reg;
    logic        advance;
    result_t     res;

    // Advance whenever the result register is free or being drained.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_ip_reg <= '0;
            region_start_reg <= '0;
            lsda_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CALL_IP:      call_ip_reg <= cfg_data;
                CFG_REGION_START: region_start_reg <= cfg_data;
                CFG_LSDA_ADDRESS: lsda_address_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register: hold the byte until the parser takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg <= last_byte;
        end
    end

    lcsl_parse #(.OFFSET_BITS(OFFSET_BITS)) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_valid_reg && advance),
        .data         (s1_data_reg),
        .first        (s1_first_reg),
        .last         (s1_last_reg),
        .call_ip      (call_ip_reg),
        .region_start (region_start_reg),
        .lsda_address (lsda_address_reg),
        .res          (res)
    );

    // Result register: load a closing result, drop a transferred one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            found_reg <= res.found;
            pad_reg <= res.pad;
            status_reg <= res.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign handler_addr = pad_reg;
    assign status       = status_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK))
        else $error("found result carries an error status");

    a_err_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (handler_addr == 64'd0 && !found))
        else $error("error result carries a landing pad");

endmodule

### hdl/lcsl_field.sv
// Byte step of one encoded field: leb128 or fixed little-endian accumulate,
// sign extension and pc-relative adjust. Uses lcsl_pkg.
module lcsl_field
    import lcsl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic [7:0]             enc,
    input  logic                   leb_force,
    input  logic [63:0]            acc,
    input  logic [6:0]             shift,
    input  logic [3:0]             left,
    input  logic [7:0]             data,
    input  logic [OFFSET_BITS-1:0] start_off,
    input  logic [63:0]            lsda_address,
    output logic [63:0]            acc_next,
    output logic [6:0]             shift_next,
    output logic [3:0]             left_next,
    output logic                   complete,
    output logic [63:0]            value
);

    logic        is_leb;
    logic [63:0] piece;
    logic [63:0] v;
    logic [5:0]  top_bit;

    assign is_leb = leb_force || enc[3:0] == FMT_ULEB || enc[3:0] == FMT_SLEB;

    always_comb
    begin
        piece = is_leb ? {57'd0, data[6:0]} : {56'd0, data};
        acc_next = shift[6] ? acc : (acc | (piece << shift[5:0]));
        left_next = left;
        if (is_leb)
        begin
            shift_next = (shift > 7'd63) ? 7'd70 : shift + 7'd7;
            complete = !data[7];
        end
        else
        begin
            shift_next = shift + 7'd8;
            left_next = (left != 4'd0) ? left - 4'd1 : 4'd0;
            complete = left_next == 4'd0;
        end
    end

    always_comb
    begin
        v = acc_next;
        top_bit = 6'(shift_next - 7'd1);
        if (enc[3:0] == FMT_SLEB)
        begin
            if (data[6] && !shift_next[6])
                v = v | ({64{1'b1}} << shift_next[5:0]);
        end
        else if (enc[3:0] == FMT_S2 || enc[3:0] == FMT_S4)
        begin
            if (shift_next != 7'd0 && !shift_next[6] && v[top_bit])
                v = v | ({64{1'b1}} << shift_next[5:0]);
        end
        if (enc[6:4] == REL_PC && v != 64'd0)
            v = v + lsda_address + 64'(start_off);
        value = v;
    end

endmodule

### hdl/lcsl_parse.sv
// Header and call-site table parser: phase register and search state,
// one LSDA byte per cycle while step is high. Uses lcsl_pkg and lcsl_field.
module lcsl_parse
    import lcsl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data,
    input  logic        first,
    input  logic        last,
    input  logic [63:0] call_ip,
    input  logic [63:0] region_start,
    input  logic [63:0] lsda_address,
    output result_t     res
);

    localparam int SW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [7:0]             enc_reg, enc_next;
    logic [63:0]            acc_reg, acc_next;
    logic [6:0]             shift_reg, shift_next;
    logic [3:0]             left_reg, left_next;
    logic [OFFSET_BITS-1:0] fso_reg, fso_next;
    logic [63:0]            pad_base_reg, pad_base_next;
    logic [OFFSET_BITS-1:0] tend_reg, tend_next;
    logic [63:0]            ebegin_reg, ebegin_next;
    logic [63:0]            espan_reg, espan_next;
    logic [1:0]             efield_reg, efield_next;
    logic                   done_reg, done_next;

    phase_t                 ph;
    logic [OFFSET_BITS-1:0] off_cur, nxt;
    logic [63:0]            f_acc, f_val, ipo;
    logic [6:0]             f_shift;
    logic [3:0]             f_left;
    logic                   f_done;
    logic [SW-1:0]          tsum;
    logic [OFFSET_BITS-1:0] tend_new;
    status_t                err;

    lcsl_field #(.OFFSET_BITS(OFFSET_BITS)) u_field (
        .enc          (enc_reg),
        .leb_force    (ph == PH_CS_LEN),
        .acc          (acc_reg),
        .shift        (shift_reg),
        .left         (left_reg),
        .data         (data),
        .start_off    (fso_reg),
        .lsda_address (lsda_address),
        .acc_next     (f_acc),
        .shift_next   (f_shift),
        .left_next    (f_left),
        .complete     (f_done),
        .value        (f_val)
    );

    assign ph      = first ? PH_LP_ENC : phase_reg;
    assign off_cur = first ? '0 : off_reg;
    assign nxt     = (off_cur == OFF_MAX) ? OFF_MAX : off_cur + 1'b1;
    assign tsum    = SW'(nxt) + SW'(f_acc[31:0]);
    assign tend_new = (tsum > SW'(OFF_MAX)) ? OFF_MAX : tsum[OFFSET_BITS-1:0];
    assign ipo     = call_ip - 64'd1 - region_start;

    always_comb
    begin
        phase_next = phase_reg;
        off_next = off_reg;
        enc_next = enc_reg;
        acc_next = acc_reg;
        shift_next = shift_reg;
        left_next = left_reg;
        fso_next = fso_reg;
        pad_base_next = pad_base_reg;
        tend_next = tend_reg;
        ebegin_next = ebegin_reg;
        espan_next = espan_reg;
        efield_next = efield_reg;
        done_next = done_reg;
        res = '{valid: 1'b0, found: 1'b0, pad: 64'd0, status: ST_OK};
        err = ST_OK;

        if (step && (first || !done_reg))
        begin
            done_next = 1'b0;
            phase_next = ph;
            off_next = nxt;
            unique case (ph)
                PH_LP_ENC:
                begin
                    enc_next = data;
                    if (data == ENC_OMIT)
                    begin
                        pad_base_next = region_start;
                        phase_next = PH_TT_ENC;
                    end
                    else
                    begin
                        err = check_enc(data);
                        acc_next = '0;
                        shift_next = '0;
                        left_next = fixed_len(data[3:0]);
                        fso_next = nxt;
                        if (err != ST_OK)
                            res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: err};
                        else
                            phase_next = PH_LP_FIELD;
                    end
                end
                PH_LP_FIELD:
                begin
                    acc_next = f_acc;
                    shift_next = f_shift;
                    left_next = f_left;
                    if (f_done)
                    begin
                        if (f_val != 64'd0 && enc_reg[7])
                            res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: ST_INDIRECT};
                        else
                        begin
                            pad_base_next = (f_val != 64'd0) ? f_val : region_start;
                            phase_next = PH_TT_ENC;
                        end
                    end
                end
                PH_TT_ENC:
                    phase_next = (data != ENC_OMIT) ? PH_TT_SKIP : PH_CS_ENC;
                PH_TT_SKIP:
                    if (!data[7])
                        phase_next = PH_CS_ENC;
                PH_CS_ENC:
                begin
                    enc_next = data;
                    acc_next = '0;
                    shift_next = '0;
                    phase_next = PH_CS_LEN;
                end
                PH_CS_LEN, PH_CS_ACTION:
                begin
                    if (ph == PH_CS_LEN)
                    begin
                        acc_next = f_acc;
                        shift_next = f_shift;
                    end
                    if (!data[7])
                    begin
                        if (ph == PH_CS_LEN)
                            tend_next = tend_new;
                        if (ph == PH_CS_ACTION && ebegin_reg <= ipo
                            && ipo < ebegin_reg + espan_reg)
                        begin
                            res = '{valid: 1'b1, found: 1'b1,
                                    pad: (acc_reg == 64'd0) ? 64'd0 : pad_base_reg + acc_reg,
                                    status: ST_OK};
                        end
                        else if (nxt >= ((ph == PH_CS_LEN) ? tend_new : tend_reg))
                            res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: ST_OK};
                        else
                        begin
                            // enter the next entry
                            efield_next = EF_START;
                            if (enc_reg == ENC_OMIT)
                            begin
                                ebegin_next = '0;
                                espan_next = '0;
                                acc_next = '0;
                                phase_next = PH_CS_ACTION;
                            end
                            else
                            begin
                                err = check_enc(enc_reg);
                                acc_next = '0;
                                shift_next = '0;
                                left_next = fixed_len(enc_reg[3:0]);
                                fso_next = nxt;
                                if (err != ST_OK)
                                    res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: err};
                                else
                                    phase_next = PH_CS_FIELD;
                            end
                        end
                    end
                end
                PH_CS_FIELD:
                begin
                    acc_next = f_acc;
                    shift_next = f_shift;
                    left_next = f_left;
                    if (f_done)
                    begin
                        if (f_val != 64'd0 && enc_reg[7])
                            res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: ST_INDIRECT};
                        else if (efield_reg == EF_PAD)
                        begin
                            acc_next = f_val;
                            phase_next = PH_CS_ACTION;
                        end
                        else
                        begin
                            if (efield_reg == EF_START)
                                ebegin_next = f_val;
                            else
                                espan_next = f_val;
                            efield_next = efield_reg + 2'd1;
                            err = check_enc(enc_reg);
                            acc_next = '0;
                            shift_next = '0;
                            left_next = fixed_len(enc_reg[3:0]);
                            fso_next = nxt;
                            if (err != ST_OK)
                                res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: err};
                        end
                    end
                end
                default:
                begin
                    // stray phase: drop the search
                    phase_next = PH_IDLE;
                    done_next = 1'b1;
                    off_next = off_reg;
                end
            endcase
            if (ph != PH_IDLE && !res.valid && last)
                res = '{valid: 1'b1, found: 1'b0, pad: 64'd0, status: ST_TRUNC};
            if (res.valid)
            begin
                done_next = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            off_reg <= '0;
            enc_reg <= '0;
            acc_reg <= '0;
            shift_reg <= '0;
            left_reg <= '0;
            fso_reg <= '0;
            pad_base_reg <= '0;
            tend_reg <= '0;
            ebegin_reg <= '0;
            espan_reg <= '0;
            efield_reg <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg <= off_next;
            enc_reg <= enc_next;
            acc_reg <= acc_next;
            shift_reg <= shift_next;
            left_reg <= left_next;
            fso_reg <= fso_next;
            pad_base_reg <= pad_base_next;
            tend_reg <= tend_next;
            ebegin_reg <= ebegin_next;
            espan_reg <= espan_next;
            efield_reg <= efield_next;
            done_reg <= done_next;
        end
    end

endmodule

### tb/sv/tb_lsda_call_site_lookup.sv
// Self-checking testbench for lsda_call_site_lookup: byte-serial LSDA streams
// checked against a behavioral predictor. Depends on lcsl_pkg and the block.
`timescale 1ns / 100ps

module tb_lsda_call_site_lookup;
    import lcsl_pkg::*;

    localparam int          OFFSET_BITS = OFFSET_BITS_DEF;
    localparam logic [32:0] OFF_MAX     = '1;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          ITEM_GOAL   = 1600;

    typedef struct {
        logic        found;
        logic [63:0] pad;
        status_t     status;
    } lookup_t;

    typedef struct {
        logic [7:0]  data;
        bit          fb;
        bit          lb;
        bit          typed;
        lookup_t     want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [63:0] handler_addr;
    logic [2:0]  status;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    lsda_call_site_lookup #(.OFFSET_BITS(OFFSET_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .first_byte(first_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .handler_addr(handler_addr), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock: 4 ns period.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the parser, advanced once per accepted
    // transfer. Register copies track every configuration write.
    // ------------------------------------------------------------------
    logic [63:0] ip_reg, region_reg, lsda_reg;
    phase_t      pr_phase;
    logic [32:0] pr_offs;
    logic [7:0]  pr_enc;
    logic [63:0] pr_acc;
    int unsigned pr_shift;
    int unsigned pr_left;
    logic [32:0] pr_fld_start;
    logic [63:0] pr_base;
    logic [32:0] pr_tbl_end;
    logic [63:0] pr_ent_begin;
    logic [63:0] pr_ent_span;
    int unsigned pr_ent_idx;
    bit          pr_idle;
    bit          pr_closed;
    lookup_t     pr_res;

    lookup_t     expected_lookups[$];

    int          n_err;
    int          n_lookups;
    int          n_bytes;
    int          cycles;
    bit          quiet;
    int          stall_left;

    // Scratch byte streams used by the LSDA generator.
    logic [7:0]  lsda_bytes[$];
    logic [7:0]  entry_bytes[$];

    function automatic logic [32:0] off_add(input logic [32:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {32'd0, a} + {1'b0, b};
        return (s > {32'd0, OFF_MAX}) ? OFF_MAX : s[32:0];
    endfunction

    function automatic int unsigned fmt_bytes(input logic [3:0] fmt);
        case (fmt)
            FMT_ABS8, FMT_U8, FMT_S8: return 8;
            FMT_U2, FMT_S2:           return 2;
            FMT_U4, FMT_S4:           return 4;
            default:                  return 0;
        endcase
    endfunction

    function automatic void close_search(input logic f, input logic [63:0] p,
                                         input status_t s);
        pr_closed     = 1'b1;
        pr_res.found  = f;
        pr_res.pad    = p;
        pr_res.status = s;
    endfunction

    // Check the active encoding and arm a field starting at offset nxt.
    function automatic status_t arm_field(input logic [32:0] nxt);
        logic [3:0] fmt;
        logic [2:0] rel;
        fmt = pr_enc[3:0];
        rel = pr_enc[6:4];
        if (!(fmt == FMT_ULEB || fmt == FMT_SLEB || fmt_bytes(fmt) != 0))
            return ST_FORMAT;
        if (rel != REL_ABS && rel != REL_PC)
            return ST_REL;
        pr_acc       = '0;
        pr_shift     = 0;
        pr_left      = fmt_bytes(fmt);
        pr_fld_start = nxt;
        return ST_OK;
    endfunction

    // Take one field byte; return 1 once the field is complete.
    function automatic bit take_field_byte(input logic [7:0] b);
        logic [3:0] fmt;
        fmt = pr_enc[3:0];
        if (fmt == FMT_ULEB || fmt == FMT_SLEB)
        begin
            if (pr_shift < 64)
                pr_acc |= {57'd0, b[6:0]} << pr_shift;
            pr_shift = (pr_shift + 7 > 70) ? 70 : pr_shift + 7;
            return !b[7];
        end
        if (pr_shift < 64)
            pr_acc |= {56'd0, b} << pr_shift;
        pr_shift += 8;
        if (pr_left > 0)
            pr_left--;
        return pr_left == 0;
    endfunction

    function automatic logic [63:0] field_result(input logic [7:0] last);
        logic [63:0] v;
        v = pr_acc;
        if (pr_enc[3:0] == FMT_SLEB)
        begin
            if (last[6] && pr_shift < 64)
                v |= ~64'd0 << pr_shift;
        end
        else if (pr_enc[3:0] == FMT_S2 || pr_enc[3:0] == FMT_S4)
        begin
            if (pr_shift > 0 && pr_shift < 64 && v[pr_shift-1])
                v |= ~64'd0 << pr_shift;
        end
        if (pr_enc[6:4] == REL_PC && v != 0)
            v += lsda_reg + {31'd0, pr_fld_start};
        return v;
    endfunction

    function automatic void open_entry(input logic [32:0] nxt);
        status_t err;
        if (nxt >= pr_tbl_end)
        begin
            close_search(1'b0, '0, ST_OK);
            return;
        end
        pr_ent_idx = 0;
        if (pr_enc == ENC_OMIT)
        begin
            // Omitted call-site encoding: entries are the action alone.
            pr_ent_begin = '0;
            pr_ent_span  = '0;
            pr_acc       = '0;
            pr_phase     = PH_CS_ACTION;
            return;
        end
        err = arm_field(nxt);
        if (err != ST_OK)
            close_search(1'b0, '0, err);
        else
            pr_phase = PH_CS_FIELD;
    endfunction

    // Advance the predictor by one accepted byte; queue any closing result.
    function automatic void track_lsda_byte(input logic [7:0] b, input bit fb, input bit lb);
        logic [32:0] nxt;
        logic [63:0] v;
        logic [63:0] ipo;
        status_t     err;
        if (fb)
        begin
            pr_idle  = 1'b0;
            pr_offs  = '0;
            pr_phase = PH_LP_ENC;
        end
        else if (pr_idle)
            return;
        pr_closed = 1'b0;
        nxt = off_add(pr_offs, 64'd1);
        case (pr_phase)
            PH_LP_ENC:
            begin
                pr_enc = b;
                if (b == ENC_OMIT)
                begin
                    pr_base  = region_reg;
                    pr_phase = PH_TT_ENC;
                end
                else
                begin
                    err = arm_field(nxt);
                    if (err != ST_OK)
                        close_search(1'b0, '0, err);
                    else
                        pr_phase = PH_LP_FIELD;
                end
            end
            PH_LP_FIELD:
            begin
                if (take_field_byte(b))
                begin
                    v = field_result(b);
                    if (v != 0 && pr_enc[7])
                        close_search(1'b0, '0, ST_INDIRECT);
                    else
                    begin
                        pr_base  = (v != 0) ? v : region_reg;
                        pr_phase = PH_TT_ENC;
                    end
                end
            end
            PH_TT_ENC:
                pr_phase = (b != ENC_OMIT) ? PH_TT_SKIP : PH_CS_ENC;
            PH_TT_SKIP:
                if (!b[7])
                    pr_phase = PH_CS_ENC;
            PH_CS_ENC:
            begin
                pr_enc   = b;
                pr_acc   = '0;
                pr_shift = 0;
                pr_phase = PH_CS_LEN;
            end
            PH_CS_LEN:
            begin
                if (pr_shift < 64)
                    pr_acc |= {57'd0, b[6:0]} << pr_shift;
                pr_shift = (pr_shift + 7 > 70) ? 70 : pr_shift + 7;
                if (!b[7])
                begin
                    pr_tbl_end = off_add(nxt, {32'd0, pr_acc[31:0]});
                    open_entry(nxt);
                end
            end
            PH_CS_FIELD:
            begin
                if (take_field_byte(b))
                begin
                    v = field_result(b);
                    if (v != 0 && pr_enc[7])
                        close_search(1'b0, '0, ST_INDIRECT);
                    else if (pr_ent_idx == 2)
                    begin
                        pr_acc   = v;
                        pr_phase = PH_CS_ACTION;
                    end
                    else
                    begin
                        if (pr_ent_idx == 0)
                            pr_ent_begin = v;
                        else
                            pr_ent_span = v;
                        pr_ent_idx++;
                        err = arm_field(nxt);
                        if (err != ST_OK)
                            close_search(1'b0, '0, err);
                    end
                end
            end
            PH_CS_ACTION:
            begin
                if (!b[7])
                begin
                    ipo = ip_reg - 64'd1 - region_reg;
                    if (pr_ent_begin <= ipo && ipo < pr_ent_begin + pr_ent_span)
                        close_search(1'b1, (pr_acc == 0) ? 64'd0 : pr_base + pr_acc, ST_OK);
                    else
                        open_entry(nxt);
                end
            end
            default:
            begin
                pr_phase = PH_IDLE;
                pr_idle  = 1'b1;
                return;
            end
        endcase
        pr_offs = nxt;
        if (!pr_closed && lb)
            close_search(1'b0, '0, ST_TRUNC);
        if (pr_closed)
        begin
            pr_idle  = 1'b1;
            pr_phase = PH_IDLE;
            expected_lookups.push_back(pr_res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each transfer against the oldest expectation,
    // then draw how long to hold off the next one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_lookups++;
            if (expected_lookups.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result found=%0b pad=%h status=%0d",
                             found, handler_addr, status);
            end
            else
            begin
                e = expected_lookups.pop_front();
                if (found !== e.found || handler_addr !== e.pad || status !== e.status)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"ERROR: result %0d expected found=%0b pad=%h status=%0d,",
                                  " got found=%0b pad=%h status=%0d"},
                                 n_lookups, e.found, e.pad, e.status,
                                 found, handler_addr, status);
                end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 8);
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("FAIL lsda_call_site_lookup");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit fb, input bit lb);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= fb;
        last_byte  <= lb;
        // Hold the transfer until the block takes it.
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        track_lsda_byte(b, fb, lb);
        n_bytes++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait out every expected result, plus the pipeline depth.
    task automatic drain();
        go_idle();
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CALL_IP:      ip_reg     = val;
            CFG_REGION_START: region_reg = val;
            default:          lsda_reg   = val;
        endcase
    endtask

    task automatic set_regs(input logic [63:0] ip, input logic [63:0] rs,
                            input logic [63:0] la);
        write_reg(CFG_CALL_IP, ip);
        write_reg(CFG_REGION_START, rs);
        write_reg(CFG_LSDA_ADDRESS, la);
    endtask

    // ------------------------------------------------------------------
    // LSDA generator
    // ------------------------------------------------------------------
    function automatic void put_value(ref logic [7:0] q[$], input logic [7:0] enc,
                                      input logic [63:0] v);
        logic signed [63:0] s;
        logic [7:0]         byt;
        bit                 fin;
        int unsigned        n;
        case (enc[3:0])
            FMT_ULEB:
            begin
                do
                begin
                    byt = {1'b0, v[6:0]};
                    v   = v >> 7;
                    q.push_back((v != 0) ? (byt | 8'h80) : byt);
                end
                while (v != 0);
            end
            FMT_SLEB:
            begin
                s = v;
                do
                begin
                    byt = {1'b0, s[6:0]};
                    s   = s >>> 7;
                    fin = (s == 0 && !byt[6]) || (s == -1 && byt[6]);
                    q.push_back(fin ? byt : (byt | 8'h80));
                end
                while (!fin);
            end
            default:
            begin
                n = fmt_bytes(enc[3:0]);
                // Unsupported formats get a few filler bytes.
                if (n == 0)
                    n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    q.push_back(v[8*i +: 8]);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_enc();
        logic [3:0] good[9] = '{FMT_ABS8, FMT_ULEB, FMT_U2, FMT_U4, FMT_U8,
                                FMT_SLEB, FMT_S2, FMT_S4, FMT_S8};
        logic [7:0] e;
        int         r;
        r = $urandom_range(0, 59);
        if (r == 0)
            return {1'b0, 3'(REL_ABS), 4'($urandom_range(5, 8))};
        if (r == 1)
            return {1'b0, 3'(REL_ABS), 4'($urandom_range(13, 15))};
        if (r == 2)
            return {1'b0, 3'($urandom_range(2, 7)), good[$urandom_range(0, 8)]};
        e = {1'b0, (r % 4 == 0) ? REL_PC : REL_ABS, good[$urandom_range(0, 8)]};
        if (r % 16 == 5)
            e[7] = 1'b1;
        return e;
    endfunction

    function automatic logic [63:0] pick_value(input logic [63:0] near);
        case ($urandom_range(0, 4))
            0:       return near - $urandom_range(0, 3);
            1:       return near;
            2:       return '0;
            3:       return {$urandom, $urandom};
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // Build one random LSDA into lsda_bytes, some with bad encodings or table length.
    function automatic void build_lsda();
        logic [7:0]  lp_enc, cs_enc;
        logic [63:0] ipo;
        logic [63:0] len;
        int          n_ent;
        lsda_bytes  = {};
        entry_bytes = {};
        ipo = ip_reg - 64'd1 - region_reg;
        lp_enc = ($urandom_range(0, 2) == 0) ? pick_enc() : ENC_OMIT;
        lsda_bytes.push_back(lp_enc);
        if (lp_enc != ENC_OMIT)
            put_value(lsda_bytes, lp_enc, pick_value(region_reg));
        if ($urandom_range(0, 1))
            lsda_bytes.push_back(ENC_OMIT);
        else
        begin
            lsda_bytes.push_back(8'($urandom_range(0, 254)));
            put_value(lsda_bytes, {4'h0, FMT_ULEB},
                      {$urandom, $urandom} >> $urandom_range(0, 63));
        end
        cs_enc = ($urandom_range(0, 15) == 0) ? ENC_OMIT : pick_enc();
        lsda_bytes.push_back(cs_enc);
        n_ent = $urandom_range(1, 4);
        for (int i = 0; i < n_ent; i++)
        begin
            if (cs_enc != ENC_OMIT)
            begin
                put_value(entry_bytes, cs_enc, pick_value(ipo));
                put_value(entry_bytes, cs_enc, $urandom_range(0, 6));
                put_value(entry_bytes, cs_enc, ($urandom_range(0, 3) == 0) ? 64'd0 :
                                               64'($urandom_range(1, 4000)));
            end
            put_value(entry_bytes, {4'h0, FMT_ULEB}, $urandom_range(0, 200));
        end
        len = entry_bytes.size();
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = len + $urandom_range(1, 5);
            2:       len = (len > 2) ? len - $urandom_range(1, 2) : len;
            3:       len = {$urandom, $urandom};
            default: ;
        endcase
        put_value(lsda_bytes, {4'h0, FMT_ULEB}, len);
        foreach (entry_bytes[i])
            lsda_bytes.push_back(entry_bytes[i]);
    endfunction

    // Send one search: mostly whole LSDAs, some with noise, cuts or garbage.
    task automatic send_search(input bit hold_for_results);
        int cut;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            lsda_bytes = {};
            repeat ($urandom_range(1, 12))
                lsda_bytes.push_back(8'($urandom));
        end
        else
            build_lsda();
        if (r == 1)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, $urandom_range(0, 1));
        cut = lsda_bytes.size();
        if (r == 2 && cut > 1)
            cut = $urandom_range(1, cut - 1);
        for (int i = 0; i < cut; i++)
            send_byte(lsda_bytes[i], i == 0,
                      (i == cut - 1) && ($urandom_range(0, 2) == 0 || r == 2));
        if (hold_for_results)
            drain();
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    dir_row_t dir_tab[$];

    function automatic void add_row(input logic [7:0] b, input bit fb, input bit lb,
                                    input bit typed = 0, input logic f = 0,
                                    input logic [63:0] p = 0, input status_t s = ST_OK);
        dir_row_t row;
        row.data       = b;
        row.fb         = fb;
        row.lb         = lb;
        row.typed      = typed;
        row.want.found  = f;
        row.want.pad    = p;
        row.want.status = s;
        dir_tab.push_back(row);
    endfunction

    function automatic void fill_dir_tab();
        // Byte outside any search: dropped.
        add_row(8'h00, 0, 0);
        // Unsupported landing-pad value format.
        add_row(8'h05, 1, 0, 1, 0, 0, ST_FORMAT);
        // Unsupported relative mode.
        add_row(8'h21, 1, 0, 1, 0, 0, ST_REL);
        // Indirect landing-pad base with a nonzero value.
        add_row(8'h81, 1, 0);
        add_row(8'h05, 0, 0, 1, 0, 0, ST_INDIRECT);
        // Last byte before the search can close.
        add_row(8'hFF, 1, 1, 1, 0, 0, ST_TRUNC);
        // Empty call-site table.
        add_row(8'hFF, 1, 0);
        add_row(8'hFF, 0, 0);
        add_row(8'h01, 0, 0);
        add_row(8'h00, 0, 0, 1, 0, 0, ST_OK);
        // Match on the first entry, type table skipped, pad = region + 7.
        add_row(8'hFF, 1, 0);
        add_row(8'h00, 0, 0);
        add_row(8'h80, 0, 0);
        add_row(8'h01, 0, 0);
        add_row(8'h01, 0, 0);
        add_row(8'h04, 0, 0);
        add_row(8'h00, 0, 0);
        add_row(8'h01, 0, 0);
        add_row(8'h07, 0, 0);
        add_row(8'h00, 0, 0, 1, 1, 64'h1007, ST_OK);
        // Omitted call-site encoding: action-only entries, runs to table end.
        add_row(8'hFF, 1, 0);
        add_row(8'hFF, 0, 0);
        add_row(8'hFF, 0, 0);
        add_row(8'h02, 0, 0);
        add_row(8'h7F, 0, 0);
        add_row(8'h00, 0, 1);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sz;
        logic [63:0] cfgs[8][3];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        first_byte = 1'b0;
        last_byte  = 1'b0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_CALL_IP;
        cfg_data   = '0;
        ip_reg = '0; region_reg = '0; lsda_reg = '0;
        pr_phase = PH_IDLE; pr_offs = '0; pr_enc = '0; pr_acc = '0;
        pr_shift = 0; pr_left = 0; pr_fld_start = '0; pr_base = '0;
        pr_tbl_end = '0; pr_ent_begin = '0; pr_ent_span = '0; pr_ent_idx = 0;
        pr_idle = 1'b1;
        n_err = 0; n_lookups = 0; n_bytes = 0; cycles = 0;
        quiet = 1'b0; stall_left = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: ipo = 0 with region 0x1000.
        set_regs(64'h1001, 64'h1000, 64'h40);
        fill_dir_tab();
        foreach (dir_tab[i])
        begin
            sz = expected_lookups.size();
            send_byte(dir_tab[i].data, dir_tab[i].fb, dir_tab[i].lb);
            if (dir_tab[i].typed && expected_lookups.size() > sz)
                expected_lookups[$] = dir_tab[i].want;
        end
        drain();

        // Random phases over several register settings, extremes included.
        cfgs = '{'{64'd0, 64'd0, 64'd0},
                 '{'1, '1, '1},
                 '{64'h1001, 64'h1000, 64'h8000},
                 '{64'd1, '1, 64'd0},
                 '{64'h40_0123, 64'h40_0000, 64'hFFFF_FFFF_FFFF_FF00},
                 '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}},
                 '{64'h8000_0000_0000_0010, 64'h8000_0000_0000_0000, 64'h1000},
                 '{64'd200, 64'd100, '1}};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_regs(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
            quiet = (ph == 5);
            while (n_bytes < dir_tab.size() + (ph + 1) * (ITEM_GOAL / 8))
                send_search(ph == 3);
            // Close any open search so the next register write lands between searches.
            send_byte(8'hFF, 1'b1, 1'b1);
            drain();
        end
        quiet = 1'b0;

        repeat (8) @(posedge clk);
        $display("Summary: %0d bytes sent, %0d lookups checked over 9 register settings,",
                 n_bytes, n_lookups);
        $display("         %0d mismatches", n_err);
        if (n_err == 0)
            $display("PASS lsda_call_site_lookup");
        else
            $display("FAIL lsda_call_site_lookup");
        $finish;
    end

endmodule

### sim.f
hdl/lcsl_pkg.sv
hdl/lcsl_field.sv
hdl/lcsl_parse.sv
hdl/lsda_call_site_lookup.sv
tb/sv/tb_lsda_call_site_lookup.sv
